// File: design/urxf_pkg.sv
// Shared types, codes and constants for the serial receiver with byte FIFO.
package urxf_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int FILL_W         = 6;
  localparam int WIDE_FILL_W    = 9;
  localparam logic [FILL_W-1:0] FILL_MAX = '1;

  // input item kinds
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_READ   = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_FLUSH  = 3'd3,
    KIND_LISTEN = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_BIT    = 2'd1,
    CFG_STOP   = 2'd2,
    CFG_INVERT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CENTER = 2'd1,
    PH_BITS   = 2'd2,
    PH_STOP   = 2'd3
  } rx_phase_t;

  // operations handed from the receiver front to the FIFO back
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_PUSH   = 3'd1,
    OP_READ   = 3'd2,
    OP_PEEK   = 3'd3,
    OP_FLUSH  = 3'd4,
    OP_LISTEN = 3'd5
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       busy;
  } cmd_t;

  // a zero delay still lasts one tick
  function automatic logic [CFG_W-1:0] ticks_min1(input logic [CFG_W-1:0] v);
    ticks_min1 = (v == '0) ? {{(CFG_W-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

// File: design/urxf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/urxf_front.sv
// Receiver front: config registers, line sampling state machine, item decode.
module urxf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [2:0]                    kind,
  input  logic                          rx_level,
  input  logic                          cfg_we,
  input  logic [urxf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urxf_pkg::CFG_W-1:0]    cfg_data,
  output urxf_pkg::cmd_t                cmd
);
  import urxf_pkg::*;

  logic [CFG_W-1:0] center_ticks;
  logic [CFG_W-1:0] bit_ticks;
  logic [CFG_W-1:0] stop_ticks;
  logic             inverted;

  rx_phase_t        phase, phase_next;
  logic [CFG_W-1:0] wait_count, wait_count_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic             prev_at_start, prev_at_start_next;

  logic             at_start;
  logic             expire;
  logic             is_tick;
  logic [CFG_W-1:0] wait_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_ticks <= '0;
      bit_ticks    <= '0;
      stop_ticks   <= '0;
      inverted     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER: center_ticks <= cfg_data;
        CFG_BIT:    bit_ticks    <= cfg_data;
        CFG_STOP:   stop_ticks   <= cfg_data;
        CFG_INVERT: inverted     <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      prev_at_start <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      prev_at_start <= prev_at_start_next;
    end
  end

  assign at_start = (rx_level == inverted);
  assign wait_dec = wait_count - {{(CFG_W-1){1'b0}}, 1'b1};
  assign expire   = (wait_dec == '0);
  assign is_tick  = (kind == KIND_TICK);

  always_comb begin
    phase_next         = phase;
    wait_count_next    = wait_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    prev_at_start_next = prev_at_start;
    cmd.op             = OP_NOP;
    cmd.data           = inverted ? ~shift_byte : shift_byte;

    unique case (kind)
      KIND_READ:   cmd.op = OP_READ;
      KIND_PEEK:   cmd.op = OP_PEEK;
      KIND_FLUSH:  cmd.op = OP_FLUSH;
      KIND_LISTEN: cmd.op = OP_LISTEN;
      default:     cmd.op = OP_NOP;
    endcase

    if (is_tick) begin
      prev_at_start_next = at_start;
      unique case (phase)
        PH_IDLE: begin
          if (at_start && !prev_at_start) begin
            phase_next      = PH_CENTER;
            wait_count_next = ticks_min1(center_ticks);
            bit_index_next  = '0;
            shift_byte_next = '0;
          end
        end
        PH_CENTER: begin
          wait_count_next = wait_dec;
          if (expire) begin
            phase_next      = PH_BITS;
            wait_count_next = ticks_min1(bit_ticks);
          end
        end
        PH_BITS: begin
          wait_count_next = wait_dec;
          if (expire) begin
            shift_byte_next[bit_index] = shift_byte[bit_index] | rx_level;
            if (bit_index == 3'd7) begin
              bit_index_next  = '0;
              phase_next      = PH_STOP;
              wait_count_next = ticks_min1(stop_ticks);
            end else begin
              bit_index_next  = bit_index + 3'd1;
              wait_count_next = ticks_min1(bit_ticks);
            end
          end
        end
        PH_STOP: begin
          wait_count_next = wait_dec;
          if (expire) begin
            // stop bit is not checked; byte goes to the FIFO
            phase_next = PH_IDLE;
            cmd.op     = OP_PUSH;
          end
        end
      endcase
    end

    cmd.busy = (phase_next != PH_IDLE);
  end

endmodule

// File: design/urxf_queue.sv
// Two-entry command queue between the receiver front and the FIFO back.
module urxf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  urxf_pkg::cmd_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output urxf_pkg::cmd_t head_entry
);
  import urxf_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_entry = slots[rd_ptr];

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop) else $error("queue popped while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop && !full |=> head_valid) else $error("queue lost an entry");
`endif

endmodule

// File: design/urxf_back.sv
// FIFO back: ring pointers, byte store, flags and the result register.
module urxf_back #(
  parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  urxf_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       byte_valid,
  output logic [7:0]                 byte_out,
  output logic [urxf_pkg::FILL_W-1:0] fill_count,
  output logic                       overrun,
  output logic                       is_listening,
  output logic                       frame_busy
);
  import urxf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic             overflow, overflow_next;
  logic             listen, listen_next;

  logic             fire;
  logic             nonempty;
  logic             full;
  logic             hit;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_q;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [WIDE_FILL_W-1:0] fill_wide;
  logic [FILL_W-1:0]      fill_sat;

  assign fire     = cmd_valid && (!out_valid || out_ready);
  assign cmd_pop  = fire;
  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign nonempty = (head != tail);
  assign full     = (tail_inc == head);
  assign hit      = listen && nonempty;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    overflow_next = overflow;
    listen_next   = listen;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (cmd.op) inside
      OP_PUSH: begin
        if (full) begin
          overflow_next = 1'b1;
        end else begin
          ram_we    = fire;
          tail_next = tail_inc;
        end
      end
      OP_READ, OP_PEEK: begin
        ram_re = fire && hit;
        if (hit && cmd.op == OP_READ) begin
          head_next = head_inc;
        end
      end
      OP_FLUSH: begin
        if (listen) begin
          head_next = '0;
          tail_next = '0;
        end
      end
      OP_LISTEN: begin
        overflow_next = 1'b0;
        head_next     = '0;
        tail_next     = '0;
        listen_next   = 1'b1;
      end
      default: ;
    endcase
  end

  // occupancy after this operation, saturated to the field width
  assign fill_wide = WIDE_FILL_W'(tail_next)
                   + ((tail_next < head_next) ? WIDE_FILL_W'(FIFO_DEPTH) : '0)
                   - WIDE_FILL_W'(head_next);
  assign fill_sat  = (fill_wide > WIDE_FILL_W'(FILL_MAX)) ? FILL_MAX
                                                          : fill_wide[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      overflow  <= 1'b0;
      listen    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        head     <= head_next;
        tail     <= tail_next;
        overflow <= overflow_next;
        listen   <= listen_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_valid   <= ram_re;
      fill_count   <= listen_next ? fill_sat : '0;
      overrun      <= overflow_next;
      is_listening <= listen_next;
      frame_busy   <= cmd.busy;
    end
  end

  // read data holds in the RAM output register until the next read
  assign byte_out = byte_valid ? ram_q : 8'd0;

  urxf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (cmd.data),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_q)
  );

`ifndef ASSERT_OFF
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (listen && nonempty)) else $error("read of an empty FIFO");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re) else $error("store written and read by one operation");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (head <= PTR_LAST) && (tail <= PTR_LAST)) else $error("pointer out of range");
  a_overflow_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow) |-> $past(fire && cmd.op == OP_PUSH))
    else $error("overflow set without a push");
  a_byte_needs_listen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> is_listening) else $error("byte returned while deaf");
`endif

endmodule

// File: design/uart_receiver_with_fifo.sv
// Top level: 8N1 serial receiver with ring byte FIFO.
//
//   port group    direction  handshake           payload
//   in            sink       in_valid/in_ready   kind, rx_level
//   out           source     out_valid/out_ready byte_valid, byte_out, fill_count,
//                                                overrun, is_listening, frame_busy
//   cfg           sink       cfg_we              cfg_index, cfg_data
//
// One item per cycle sustained while out_ready holds. Each command passes the two-entry
// command queue, then the result register; these two let either side stall alone.
// The front runs the line state machine in the transfer cycle, the back does one FIFO
// operation per cycle unless stalled, through a single-port-write, registered-read byte
// store. Reset clears pointers, flags and receiver state; the store is not cleared.
module uart_receiver_with_fifo #(
  parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     kind,
  input  logic                           rx_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           byte_valid,
  output logic [7:0]                     byte_out,
  output logic [urxf_pkg::FILL_W-1:0]    fill_count,
  output logic                           overrun,
  output logic                           is_listening,
  output logic                           frame_busy,
  input  logic                           cfg_we,
  input  logic [urxf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urxf_pkg::CFG_W-1:0]     cfg_data
);
  import urxf_pkg::*;

  logic take;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t front_cmd;
  cmd_t q_cmd;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  urxf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .kind      (kind),
    .rx_level  (rx_level),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (front_cmd)
  );

  urxf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_entry (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_cmd)
  );

  urxf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_pop      (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .byte_out     (byte_out),
    .fill_count   (fill_count),
    .overrun      (overrun),
    .is_listening (is_listening),
    .frame_busy   (frame_busy)
  );

endmodule

// File: tb/urxf_checker.sv
// Checker: watches both channels, predicts the receiver/FIFO status per transfer, compares.
module urxf_checker #(
  parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [2:0]                     kind,
  input  logic                           rx_level,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           byte_valid,
  input  logic [7:0]                     byte_out,
  input  logic [urxf_pkg::FILL_W-1:0]    fill_count,
  input  logic                           overrun,
  input  logic                           is_listening,
  input  logic                           frame_busy,
  input  logic                           cfg_we,
  input  logic [urxf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urxf_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                    backlog,
  output int unsigned                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import urxf_pkg::*;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        byte_out;
    logic [FILL_W-1:0] fill_count;
    logic              overrun;
    logic              is_listening;
    logic              frame_busy;
  } rx_status_t;

  // shadow configuration
  logic [CFG_W-1:0] center_r, bitper_r, stop_r;
  logic             inv_r;

  // shadow receiver and FIFO
  logic [7:0]       fifo_img [FIFO_DEPTH];
  int unsigned      head_i, tail_i;
  logic             ovf_r, listen_r;
  rx_phase_t        phase_r;
  logic [CFG_W-1:0] wait_r;
  logic [2:0]       bit_r;
  logic [7:0]       shift_r;
  logic             prev_start_r;

  rx_status_t  status_q [$];
  int unsigned result_no;

  initial begin
    backlog = 0;
    mismatches = 0;
    result_no = 0;
  end

  function automatic logic [CFG_W-1:0] dwell(input logic [CFG_W-1:0] v);
    return (v == '0) ? CFG_W'(1) : v;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    int unsigned nxt;
    nxt = (tail_i + 1) % FIFO_DEPTH;
    if (nxt != head_i) begin
      fifo_img[tail_i] = b;
      tail_i = nxt;
    end else begin
      ovf_r = 1'b1;
    end
  endfunction

  function automatic void sample_line(input logic lvl);
    logic at_start;
    at_start = (lvl == inv_r);
    case (phase_r)
      PH_IDLE: begin
        if (at_start && !prev_start_r) begin
          phase_r = PH_CENTER;
          wait_r  = dwell(center_r);
          bit_r   = '0;
          shift_r = '0;
        end
      end
      PH_CENTER: begin
        wait_r = wait_r - 1'b1;
        if (wait_r == '0) begin
          phase_r = PH_BITS;
          wait_r  = dwell(bitper_r);
        end
      end
      PH_BITS: begin
        wait_r = wait_r - 1'b1;
        if (wait_r == '0) begin
          if (lvl) shift_r[bit_r] = 1'b1;
          if (bit_r == 3'd7) begin
            bit_r   = '0;
            phase_r = PH_STOP;
            wait_r  = dwell(stop_r);
          end else begin
            bit_r  = bit_r + 1'b1;
            wait_r = dwell(bitper_r);
          end
        end
      end
      default: begin
        // stop level is never checked; polarity is taken at push time
        wait_r = wait_r - 1'b1;
        if (wait_r == '0) begin
          store_byte(inv_r ? ~shift_r : shift_r);
          phase_r = PH_IDLE;
        end
      end
    endcase
    prev_start_r = at_start;
  endfunction

  function automatic rx_status_t apply_item(input logic [2:0] k, input logic lvl);
    rx_status_t  s;
    int unsigned fill;
    s = '0;
    case (k) inside
      KIND_TICK: sample_line(lvl);
      KIND_READ, KIND_PEEK: begin
        if (listen_r && head_i != tail_i) begin
          s.byte_valid = 1'b1;
          s.byte_out   = fifo_img[head_i];
          if (k == KIND_READ) head_i = (head_i + 1) % FIFO_DEPTH;
        end
      end
      KIND_FLUSH: begin
        if (listen_r) begin
          head_i = 0;
          tail_i = 0;
        end
      end
      KIND_LISTEN: begin
        ovf_r    = 1'b0;
        head_i   = 0;
        tail_i   = 0;
        listen_r = 1'b1;
      end
      default: ;
    endcase
    fill = listen_r ? (tail_i + FIFO_DEPTH - head_i) % FIFO_DEPTH : 0;
    s.fill_count   = (fill > FILL_MAX) ? FILL_MAX : FILL_W'(fill);
    s.overrun      = ovf_r;
    s.is_listening = listen_r;
    s.frame_busy   = (phase_r != PH_IDLE);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                result_no, name, got_v, want_v));
  endtask

  always @(posedge clk) begin : watch
    rx_status_t want;
    if (rst) begin
      center_r     = '0;
      bitper_r     = '0;
      stop_r       = '0;
      inv_r        = 1'b0;
      head_i       = 0;
      tail_i       = 0;
      ovf_r        = 1'b0;
      listen_r     = 1'b0;
      phase_r      = PH_IDLE;
      wait_r       = '0;
      bit_r        = '0;
      shift_r      = '0;
      prev_start_r = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER: center_r = cfg_data;
          CFG_BIT:    bitper_r = cfg_data;
          CFG_STOP:   stop_r   = cfg_data;
          CFG_INVERT: inv_r    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) status_q.push_back(apply_item(kind, rx_level));
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", result_no));
        end else begin
          want = status_q.pop_front();
          check_field("byte_valid", 8'(byte_valid), 8'(want.byte_valid));
          check_field("byte_out", byte_out, want.byte_out);
          check_field("fill_count", 8'(fill_count), 8'(want.fill_count));
          check_field("overrun", 8'(overrun), 8'(want.overrun));
          check_field("is_listening", 8'(is_listening), 8'(want.is_listening));
          check_field("frame_busy", 8'(frame_busy), 8'(want.frame_busy));
        end
        result_no++;
      end
    end
    backlog = status_q.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, serial-line and FIFO stimulus, and the final verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import urxf_pkg::*;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          TARGET_ITEMS  = 1950;
  localparam int          FILL_FRAMES   = 66;   // one more frame than fits, plus margin
  localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           kind = KIND_TICK;
  logic                 rx_level = 1'b1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 byte_valid;
  logic [7:0]           byte_out;
  logic [FILL_W-1:0]    fill_count;
  logic                 overrun;
  logic                 is_listening;
  logic                 frame_busy;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER;
  logic [CFG_W-1:0]     cfg_data = '0;

  int unsigned backlog;
  int unsigned mismatches;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;

  // stimulus-side copy of the delays, only used to shape frames
  logic [CFG_W-1:0] sh_center = '0, sh_bit = '0, sh_stop = '0;
  logic             sh_inv = 1'b0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int op_pct = 0;
  int flip_pct = 0;

  uart_receiver_with_fifo u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .rx_level     (rx_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .byte_out     (byte_out),
    .fill_count   (fill_count),
    .overrun      (overrun),
    .is_listening (is_listening),
    .frame_busy   (frame_busy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  urxf_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .rx_level     (rx_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .byte_out     (byte_out),
    .fill_count   (fill_count),
    .overrun      (overrun),
    .is_listening (is_listening),
    .frame_busy   (frame_busy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .backlog      (backlog),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("uart_receiver_with_fifo verification failed");
      $finish;
    end
  end

  // result side: random stall before each transfer while rx_idle is set
  initial begin : drain
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (rx_idle) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [2:0] k, input logic lvl);
    if (tx_idle) repeat ($urandom_range(0, 10)) @(negedge clk);
    kind = k;
    rx_level = lvl;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    if (k <= KIND_LISTEN) items_sent++;
  endtask

  task automatic fifo_op();
    int   pick;
    logic lvl;
    pick = $urandom_range(0, 99);
    lvl = 1'($urandom);
    if (pick < 45) send_item(KIND_READ, lvl);
    else if (pick < 70) send_item(KIND_PEEK, lvl);
    else if (pick < 78) send_item(KIND_FLUSH, lvl);
    else if (pick < 84) send_item(KIND_LISTEN, lvl);
    else send_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), lvl);
  endtask

  // one line sample, sometimes preceded by a FIFO access or spare-kind item, sometimes corrupted
  task automatic line_tick(input logic lvl);
    if ($urandom_range(0, 99) < op_pct) fifo_op();
    send_item(KIND_TICK, lvl ^ ($urandom_range(0, 99) < flip_pct));
  endtask

  // 8N1 frame timed to the current delays: lead idle samples, start, LSB first, stop
  task automatic send_frame(input logic [7:0] data, input int lead);
    int c, b, s;
    c = (sh_center == '0) ? 1 : sh_center;
    b = (sh_bit == '0) ? 1 : sh_bit;
    s = (sh_stop == '0) ? 1 : sh_stop;
    repeat (lead) line_tick(!sh_inv);
    repeat (c + 1) line_tick(sh_inv);
    for (int i = 0; i < 8; i++) repeat (b) line_tick(data[i] ^ sh_inv);
    repeat (s) line_tick(!sh_inv);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_we = 1'b1;
    case (idx)
      CFG_CENTER: sh_center = val;
      CFG_BIT:    sh_bit = val;
      CFG_STOP:   sh_stop = val;
      default:    sh_inv = val[0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (backlog != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_delay();
    return ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 3))
                                       : CFG_W'($urandom_range(4, 15));
  endfunction

  task automatic run_phase(input int n);
    int stop_at;
    stop_at = items_sent + n;
    wait_drained();
    write_reg(CFG_CENTER, pick_delay());
    write_reg(CFG_BIT, pick_delay());
    write_reg(CFG_STOP, pick_delay());
    write_reg(CFG_INVERT, CFG_W'($urandom));
    op_pct = $urandom_range(3, 30);
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 8)) line_tick(1'($urandom));
        1: begin
          flip_pct = 20;
          send_frame(8'($urandom), $urandom_range(0, 3));
          flip_pct = 0;
        end
        default: send_frame(8'($urandom), $urandom_range(1, 3));
      endcase
    end
  endtask

  initial begin : stim
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: FIFO access before listen, spare kind, frame right out of reset
    send_item(KIND_READ, 1'b1);
    send_item(KIND_PEEK, 1'b0);
    send_item(KIND_FLUSH, 1'b1);
    send_item(KIND_SPARE_HI, 1'b1);
    send_frame(8'hA5, 0);  // line low from reset counts as a start edge
    send_item(KIND_LISTEN, 1'b0);
    send_item(KIND_PEEK, 1'b1);
    send_item(KIND_READ, 1'b0);
    send_item(KIND_FLUSH, 1'b0);

    // hold off until every outstanding transfer has come back
    wait_drained();
    run_phase(250);

    // zero delays, no reads: overfill the FIFO, then drain a bit and clear
    wait_drained();
    write_reg(CFG_CENTER, '0);
    write_reg(CFG_BIT, '0);
    write_reg(CFG_STOP, '0);
    write_reg(CFG_INVERT, '0);
    op_pct = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    send_item(KIND_LISTEN, 1'b1);
    repeat (FILL_FRAMES) send_frame(8'($urandom), $urandom_range(1, 2));
    send_item(KIND_PEEK, 1'b0);
    repeat (3) send_item(KIND_READ, 1'b1);
    send_item(KIND_LISTEN, 1'b0);

    while (items_sent < TARGET_ITEMS - 60) run_phase($urandom_range(150, 300));

    // maximum delays; a frame that starts here stays open to the end
    wait_drained();
    write_reg(CFG_CENTER, '1);
    write_reg(CFG_BIT, '1);
    write_reg(CFG_STOP, '1);
    write_reg(CFG_INVERT, '1);
    op_pct = 20;
    tx_idle = 1'b1;
    repeat (3) line_tick(1'b0);
    repeat (60) line_tick(1'($urandom));

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("uart_receiver_with_fifo verification clean");
    else
      $display("uart_receiver_with_fifo verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/urxf_pkg.sv
design/urxf_ram.sv
design/urxf_front.sv
design/urxf_queue.sv
design/urxf_back.sv
design/uart_receiver_with_fifo.sv
tb/urxf_checker.sv
tb/tb.sv
